// ===== rtl/mp3fhd_pkg.sv =====
// mp3fhd_pkg: status codes and constant lookup tables for the mpeg-1 layer iii header decoder
// no dependencies; used by mp3_frame_header_decode
package mp3fhd_pkg;

  localparam int unsigned HeaderWidth  = 32;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned BitrateWidth = 19;
  localparam int unsigned RateWidth    = 16;
  localparam int unsigned FrameWidth   = 11;

  // frame length used when the computed size is zero (free format or bad bitrate code, no padding)
  localparam logic [FrameWidth-1:0] FrameFallback = 11'd418;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_VALID = 2'd0,
    STATUS_TAG   = 2'd1,
    STATUS_ERROR = 2'd2
  } status_e;

  // sample rate code, b2 bits 3..2
  typedef enum logic [1:0] {
    SR_44K1 = 2'd0,
    SR_48K  = 2'd1,
    SR_32K  = 2'd2,
    SR_RSVD = 2'd3
  } srate_e;

  // layer iii bitrate table in bits per second, free and bad codes give 0
  function automatic logic [BitrateWidth-1:0] bitrate_lookup(input logic [3:0] code);
    logic [BitrateWidth-1:0] bps;
    case (code)
      4'd1:    bps = 19'd32000;
      4'd2:    bps = 19'd40000;
      4'd3:    bps = 19'd48000;
      4'd4:    bps = 19'd56000;
      4'd5:    bps = 19'd64000;
      4'd6:    bps = 19'd80000;
      4'd7:    bps = 19'd96000;
      4'd8:    bps = 19'd112000;
      4'd9:    bps = 19'd128000;
      4'd10:   bps = 19'd160000;
      4'd11:   bps = 19'd192000;
      4'd12:   bps = 19'd224000;
      4'd13:   bps = 19'd256000;
      4'd14:   bps = 19'd320000;
      default: bps = '0;
    endcase
    return bps;
  endfunction

  // sample rate in hz, reserved code falls back to 32 khz
  function automatic logic [RateWidth-1:0] rate_lookup(input logic [1:0] code);
    logic [RateWidth-1:0] hz;
    case (code)
      SR_44K1: hz = 16'd44100;
      SR_48K:  hz = 16'd48000;
      default: hz = 16'd32000;
    endcase
    return hz;
  endfunction

  // floor(144 * bitrate / rate) at 44.1 khz
  function automatic logic [FrameWidth-1:0] frame_44k1(input logic [3:0] code);
    logic [FrameWidth-1:0] n;
    case (code)
      4'd1:    n = 11'd104;
      4'd2:    n = 11'd130;
      4'd3:    n = 11'd156;
      4'd4:    n = 11'd182;
      4'd5:    n = 11'd208;
      4'd6:    n = 11'd261;
      4'd7:    n = 11'd313;
      4'd8:    n = 11'd365;
      4'd9:    n = 11'd417;
      4'd10:   n = 11'd522;
      4'd11:   n = 11'd626;
      4'd12:   n = 11'd731;
      4'd13:   n = 11'd835;
      4'd14:   n = 11'd1044;
      default: n = '0;
    endcase
    return n;
  endfunction

  // floor(144 * bitrate / rate) at 48 khz
  function automatic logic [FrameWidth-1:0] frame_48k(input logic [3:0] code);
    logic [FrameWidth-1:0] n;
    case (code)
      4'd1:    n = 11'd96;
      4'd2:    n = 11'd120;
      4'd3:    n = 11'd144;
      4'd4:    n = 11'd168;
      4'd5:    n = 11'd192;
      4'd6:    n = 11'd240;
      4'd7:    n = 11'd288;
      4'd8:    n = 11'd336;
      4'd9:    n = 11'd384;
      4'd10:   n = 11'd480;
      4'd11:   n = 11'd576;
      4'd12:   n = 11'd672;
      4'd13:   n = 11'd768;
      4'd14:   n = 11'd960;
      default: n = '0;
    endcase
    return n;
  endfunction

  // floor(144 * bitrate / rate) at 32 khz
  function automatic logic [FrameWidth-1:0] frame_32k(input logic [3:0] code);
    logic [FrameWidth-1:0] n;
    case (code)
      4'd1:    n = 11'd144;
      4'd2:    n = 11'd180;
      4'd3:    n = 11'd216;
      4'd4:    n = 11'd252;
      4'd5:    n = 11'd288;
      4'd6:    n = 11'd360;
      4'd7:    n = 11'd432;
      4'd8:    n = 11'd504;
      4'd9:    n = 11'd576;
      4'd10:   n = 11'd720;
      4'd11:   n = 11'd864;
      4'd12:   n = 11'd1008;
      4'd13:   n = 11'd1152;
      4'd14:   n = 11'd1440;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/mp3_frame_header_decode.sv =====
// mp3_frame_header_decode: decodes one 32-bit mpeg-1 layer iii frame header candidate
// depends on mp3fhd_pkg for status codes and the bitrate, rate and frame size tables
//
// usage:
//   input channel  valid_i / stall_o / header_word_i, first header byte in bits 31..24
//   output channel valid_o / stall_i / status_o, protection_bit_o, padded_o,
//                  bitrate_bps_o, sample_rate_hz_o, frame_bytes_o
//   a request is taken on a rising edge with valid high and stall low
//   each header gives exactly one result
//   result path: input register, then result register, which drives valid_o
//   throughput: one header per cycle while stall_i is low; the decode is table lookups
//     and one small add between the two registers, so the clock rate sets the header rate
//   receiver stall: the result register holds its contents; the input register keeps
//     filling, and stall_o rises only once both registers are full and stall_i is high
//   reset: rst_ni clears both valid flags; the data registers are not reset
module mp3_frame_header_decode (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic [mp3fhd_pkg::HeaderWidth-1:0]   header_word_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [mp3fhd_pkg::StatusWidth-1:0]   status_o,
  output logic                                 protection_bit_o,
  output logic                                 padded_o,
  output logic [mp3fhd_pkg::BitrateWidth-1:0]  bitrate_bps_o,
  output logic [mp3fhd_pkg::RateWidth-1:0]     sample_rate_hz_o,
  output logic [mp3fhd_pkg::FrameWidth-1:0]    frame_bytes_o
);

  logic                                in_valid_q;
  logic [mp3fhd_pkg::HeaderWidth-1:0]  word_q;
  logic                                out_valid_q;
  logic                                out_load;
  logic                                in_load;

  logic [7:0] b0, b1, b2;
  logic       sync, mpeg1, layer3, tag;
  logic [3:0] br_code;
  logic [1:0] sr_code;
  logic [mp3fhd_pkg::FrameWidth-1:0] base_size;
  logic [mp3fhd_pkg::FrameWidth-1:0] sum_size;

  logic [mp3fhd_pkg::StatusWidth-1:0]  status_d,  status_q;
  logic                                prot_d,    prot_q;
  logic                                pad_d,     pad_q;
  logic [mp3fhd_pkg::BitrateWidth-1:0] bitrate_d, bitrate_q;
  logic [mp3fhd_pkg::RateWidth-1:0]    rate_d,    rate_q;
  logic [mp3fhd_pkg::FrameWidth-1:0]   size_d,    size_q;

  // flow control: result register loads from a full input register when empty or drained this cycle
  assign out_load = in_valid_q && (!out_valid_q || !stall_i);
  assign in_load  = valid_i && !stall_o;
  assign stall_o  = in_valid_q && !out_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (out_load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      word_q <= header_word_i;
    end
  end

  // field extraction
  assign b0      = word_q[31:24];
  assign b1      = word_q[23:16];
  assign b2      = word_q[15:8];
  assign br_code = b2[7:4];
  assign sr_code = b2[3:2];

  assign sync   = (b0 == 8'hFF) && ((b1 & 8'hE0) == 8'hE0);
  assign mpeg1  = (b1 & 8'h18) == 8'h18;
  assign layer3 = (b1 & 8'h06) == 8'h02;
  assign tag    = (b0 == 8'h54) && (b1 == 8'h41) && (b2 == 8'h47);

  // status, valid header wins over tag
  always_comb begin
    if (sync && mpeg1 && layer3) begin
      status_d = mp3fhd_pkg::STATUS_VALID;
    end else if (tag) begin
      status_d = mp3fhd_pkg::STATUS_TAG;
    end else begin
      status_d = mp3fhd_pkg::STATUS_ERROR;
    end
  end

  // frame size table select by sample rate
  always_comb begin
    unique case (sr_code)
      mp3fhd_pkg::SR_44K1: base_size = mp3fhd_pkg::frame_44k1(br_code);
      mp3fhd_pkg::SR_48K:  base_size = mp3fhd_pkg::frame_48k(br_code);
      default:             base_size = mp3fhd_pkg::frame_32k(br_code);
    endcase
  end

  assign prot_d    = b1[0];
  assign pad_d     = b2[1];
  assign bitrate_d = mp3fhd_pkg::bitrate_lookup(br_code);
  assign rate_d    = mp3fhd_pkg::rate_lookup(sr_code);
  assign sum_size  = base_size + {{(mp3fhd_pkg::FrameWidth-1){1'b0}}, pad_d};
  assign size_d    = (sum_size == '0) ? mp3fhd_pkg::FrameFallback : sum_size;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      prot_q    <= prot_d;
      pad_q     <= pad_d;
      bitrate_q <= bitrate_d;
      rate_q    <= rate_d;
      size_q    <= size_d;
    end
  end

  assign valid_o          = out_valid_q;
  assign status_o         = status_q;
  assign protection_bit_o = prot_q;
  assign padded_o         = pad_q;
  assign bitrate_bps_o    = bitrate_q;
  assign sample_rate_hz_o = rate_q;
  assign frame_bytes_o    = size_q;

endmodule

// ===== sim/tb_mp3_frame_header_decode.sv =====
`timescale 1ns / 100ps
// tb_mp3_frame_header_decode: self-checking bench for the mpeg-1 layer iii header decoder
// depends on mp3fhd_pkg and mp3_frame_header_decode; decodes each header locally and
// compares every result field, with random idling on both channels and one long hold-off
module tb_mp3_frame_header_decode;

  localparam int unsigned RandomHeaders = 1000;
  localparam int unsigned TailItems     = 100;   // last headers go through without idling
  localparam int unsigned HoldAt        = 300;   // long output hold-off starts here
  localparam int unsigned HoldCycles    = 64;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 10;

  typedef struct packed {
    mp3fhd_pkg::status_e                 status;
    logic                                prot;
    logic                                pad;
    logic [mp3fhd_pkg::BitrateWidth-1:0] bps;
    logic [mp3fhd_pkg::RateWidth-1:0]    hz;
    logic [mp3fhd_pkg::FrameWidth-1:0]   bytes;
  } header_fields_t;

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 valid_i       = 1'b0;
  logic [mp3fhd_pkg::HeaderWidth-1:0]   header_word_i = '0;
  logic                                 stall_i       = 1'b0;
  logic                                 stall_o;
  logic                                 valid_o;
  logic [mp3fhd_pkg::StatusWidth-1:0]   status_o;
  logic                                 protection_bit_o;
  logic                                 padded_o;
  logic [mp3fhd_pkg::BitrateWidth-1:0]  bitrate_bps_o;
  logic [mp3fhd_pkg::RateWidth-1:0]     sample_rate_hz_o;
  logic [mp3fhd_pkg::FrameWidth-1:0]    frame_bytes_o;

  logic [mp3fhd_pkg::HeaderWidth-1:0]   header_queue[$];
  header_fields_t           pending_decodes[$];
  logic                     in_taken   = 1'b0;
  int unsigned              send_gap   = 0;
  int unsigned              stall_left = 0;
  int unsigned              hold_left  = 0;
  logic                     hold_done  = 1'b0;
  int unsigned              headers_in = 0;
  int unsigned              results_out = 0;
  int unsigned              n_valid = 0, n_tag = 0, n_error = 0;
  int unsigned              errors = 0;
  int unsigned              idle_cycles = 0;

  mp3_frame_header_decode u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .header_word_i    (header_word_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .status_o         (status_o),
    .protection_bit_o (protection_bit_o),
    .padded_o         (padded_o),
    .bitrate_bps_o    (bitrate_bps_o),
    .sample_rate_hz_o (sample_rate_hz_o),
    .frame_bytes_o    (frame_bytes_o)
  );

  // expected decode of one header word
  function automatic header_fields_t decode_header(
    input logic [mp3fhd_pkg::HeaderWidth-1:0] w
  );
    header_fields_t r;
    logic [7:0]     b0, b1, b2;
    int unsigned    kbps, bps, hz, bytes;
    b0 = w[31:24];
    b1 = w[23:16];
    b2 = w[15:8];
    if (b0 == 8'hFF && (b1 & 8'hE0) == 8'hE0 && (b1 & 8'h18) == 8'h18 &&
        (b1 & 8'h06) == 8'h02) begin
      r.status = mp3fhd_pkg::STATUS_VALID;
    end else if (b0 == 8'h54 && b1 == 8'h41 && b2 == 8'h47) begin
      r.status = mp3fhd_pkg::STATUS_TAG;
    end else begin
      r.status = mp3fhd_pkg::STATUS_ERROR;
    end
    case (b2[7:4])
      4'd1:    kbps = 32;
      4'd2:    kbps = 40;
      4'd3:    kbps = 48;
      4'd4:    kbps = 56;
      4'd5:    kbps = 64;
      4'd6:    kbps = 80;
      4'd7:    kbps = 96;
      4'd8:    kbps = 112;
      4'd9:    kbps = 128;
      4'd10:   kbps = 160;
      4'd11:   kbps = 192;
      4'd12:   kbps = 224;
      4'd13:   kbps = 256;
      4'd14:   kbps = 320;
      default: kbps = 0;
    endcase
    case (mp3fhd_pkg::srate_e'(b2[3:2]))
      mp3fhd_pkg::SR_44K1: hz = 44100;
      mp3fhd_pkg::SR_48K:  hz = 48000;
      default:             hz = 32000;
    endcase
    bps   = kbps * 1000;
    bytes = (144 * bps) / hz + b2[1];
    if (bytes == 0) bytes = 418;
    r.prot  = b1[0];
    r.pad   = b2[1];
    r.bps   = bps[mp3fhd_pkg::BitrateWidth-1:0];
    r.hz    = hz[mp3fhd_pkg::RateWidth-1:0];
    r.bytes = bytes[mp3fhd_pkg::FrameWidth-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // request driver, fed from header_queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else if (valid_i && !in_taken) begin
      // stalled, hold the payload
    end else if (send_gap > 0) begin
      valid_i  <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (header_queue.size() == 0) begin
      valid_i <= 1'b0;
    end else if (header_queue.size() > TailItems && $urandom_range(0, 9) == 0) begin
      valid_i  <= 1'b0;
      send_gap <= $urandom_range(1, 16) - 1;
    end else begin
      valid_i       <= 1'b1;
      header_word_i <= header_queue.pop_front();
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      stall_i   <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && headers_in >= HoldAt) begin
      stall_i   <= 1'b1;
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_i    <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (header_queue.size() > TailItems && $urandom_range(0, 7) == 0) begin
      stall_i    <= 1'b1;
      stall_left <= $urandom_range(1, 16) - 1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    header_fields_t want;
    in_taken <= rst_ni && valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o) begin
      pending_decodes.push_back(decode_header(header_word_i));
      headers_in++;
    end
    if (rst_ni && valid_o && !stall_i) begin
      results_out++;
      if (pending_decodes.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = pending_decodes.pop_front();
        case (want.status)
          mp3fhd_pkg::STATUS_VALID: n_valid++;
          mp3fhd_pkg::STATUS_TAG:   n_tag++;
          default:                  n_error++;
        endcase
        check_field("status", want.status, status_o);
        check_field("protection_bit", want.prot, protection_bit_o);
        check_field("padded", want.pad, padded_o);
        check_field("bitrate_bps", want.bps, bitrate_bps_o);
        check_field("sample_rate_hz", want.hz, sample_rate_hz_o);
        check_field("frame_bytes", want.bytes, frame_bytes_o);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("mp3_frame_header_decode verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] w;
    // directed: extremes, every status and the size special cases
    header_queue.push_back(32'hFFFB9000);  // 128k at 44.1k
    header_queue.push_back(32'hFFFB9200);  // same, padded
    header_queue.push_back(32'hFFFA9000);  // crc present
    header_queue.push_back(32'hFFFBE000);  // 320k at 44.1k
    header_queue.push_back(32'hFFFBEA00);  // 320k at 32k padded, largest frame
    header_queue.push_back(32'hFFFB1400);  // 32k at 48k, smallest sized frame
    header_queue.push_back(32'hFFFB0000);  // free format unpadded, fallback size
    header_queue.push_back(32'hFFFB0200);  // free format padded
    header_queue.push_back(32'hFFFBF000);  // bad bitrate code
    header_queue.push_back(32'hFFFBF200);  // bad bitrate code, padded
    header_queue.push_back(32'hFFFB9C00);  // reserved sample rate
    header_queue.push_back(32'hFFFB9800);  // 32k sample rate
    header_queue.push_back(32'h54414700);  // tag start
    header_queue.push_back(32'h544147FF);  // tag start, last byte set
    header_queue.push_back(32'h54414800);  // almost a tag
    header_queue.push_back(32'h54404700);  // almost a tag
    header_queue.push_back(32'hFFDB9000);  // sync bit missing in second byte
    header_queue.push_back(32'hFEFB9000);  // sync bit missing in first byte
    header_queue.push_back(32'hFFF39000);  // mpeg-2
    header_queue.push_back(32'hFFEB9000);  // reserved version
    header_queue.push_back(32'hFFFF9000);  // layer i
    header_queue.push_back(32'hFFFD9000);  // layer ii
    header_queue.push_back(32'hFFF99000);  // reserved layer
    header_queue.push_back(32'h00000000);
    header_queue.push_back(32'hFFFFFFFF);
    // random: mostly well-formed headers with random content
    repeat (RandomHeaders) begin
      case ($urandom_range(0, 9)) inside
        [0:5]: begin
          w = $urandom();
          w[31:24] = 8'hFF;
          w[23:17] = 7'b1111101;
        end
        6: begin
          w = $urandom();
          w[31:8] = 24'h544147;
        end
        7: begin
          w = $urandom();
          w[31:21] = 11'h7FF;
        end
        8: begin
          w = $urandom();
          w[31:8] = 24'h544147 ^ (24'h1 << $urandom_range(0, 23));
        end
        default: w = $urandom();
      endcase
      header_queue.push_back(w);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // all requests taken, then all results back, then a short drain
    while (header_queue.size() != 0 || valid_i) @(posedge clk_i);
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("decoded %0d headers (%0d valid, %0d tag, %0d error)", results_out, n_valid,
             n_tag, n_error);
    $display("random idling on both channels plus a %0d-cycle output hold-off", HoldCycles);
    if (errors == 0) begin
      $display("mp3_frame_header_decode verification clean");
    end else begin
      $display("mp3_frame_header_decode verification failed");
    end
    $finish;
  end

endmodule

// ===== mp3_frame_header_decode.f =====
rtl/mp3fhd_pkg.sv
rtl/mp3_frame_header_decode.sv
sim/tb_mp3_frame_header_decode.sv
